### hdl/lmt_pkg.sv
// ----------------------------------------------------------------------------
// lmt_pkg
// Shared types and constants for the display mode and scanline timing block.
// ----------------------------------------------------------------------------
package lmt_pkg;

   localparam int unsigned TICK_W    = 6;
   localparam int unsigned ACC_W     = 10;
   localparam int unsigned LINE_W    = 8;
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned STAT_EN_W = 3;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 16;

   // phase lengths in ticks
   localparam logic [ACC_W-1:0] LEN_OAM    = 10'd80;
   localparam logic [ACC_W-1:0] LEN_XFER   = 10'd172;
   localparam logic [ACC_W-1:0] LEN_HBLANK = 10'd204;
   localparam logic [ACC_W-1:0] LEN_VLINE  = 10'd456;

   // line bounds, compared against the untruncated next line
   localparam logic [LINE_W:0] VISIBLE_LINES = 9'd144;
   localparam logic [LINE_W:0] LAST_LINE     = 9'd153;

   // stat enable bit positions
   localparam int unsigned STAT_EN_HBLANK = 0;
   localparam int unsigned STAT_EN_VBLANK = 1;
   localparam int unsigned STAT_EN_OAM    = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_XFER   = 2'd3
   } mode_type;

   // packed so that mode lands in the lowest bits
   typedef struct packed {
      logic              frame_done;
      logic              render_request;
      logic              stat_irq;
      logic              vblank_irq;
      logic [LINE_W-1:0] line;
      logic [MODE_W-1:0] mode;
   } result_type;

   localparam int unsigned RESULT_W = $bits(result_type);

endpackage

### hdl/lmt_step.sv
// ----------------------------------------------------------------------------
// lmt_step
// Timing state (mode, line, tick accumulator) and the one-transition step
// applied to each accepted tick count.
// ----------------------------------------------------------------------------
module lmt_step (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step_valid,
   input  logic [lmt_pkg::TICK_W-1:0]      tick_count,
   input  logic                            csr_wr_en,
   input  logic [lmt_pkg::STAT_EN_W-1:0]   csr_wr_data,
   output lmt_pkg::result_type             result
);

   lmt_pkg::mode_type                   mode_ff, mode_in;
   logic [lmt_pkg::LINE_W-1:0]          line_ff, line_in;
   logic [lmt_pkg::ACC_W-1:0]           acc_ff, acc_in;
   logic [lmt_pkg::STAT_EN_W-1:0]       stat_en_ff;

   logic [lmt_pkg::ACC_W-1:0]           acc_sum;
   logic [lmt_pkg::ACC_W-1:0]           phase_len;
   logic                                phase_end;
   logic [lmt_pkg::LINE_W:0]            line_inc;

   always_comb begin
      acc_sum  = acc_ff + {{(lmt_pkg::ACC_W-lmt_pkg::TICK_W){1'b0}}, tick_count};
      line_inc = {1'b0, line_ff} + 9'd1;
      unique case (mode_ff)
         lmt_pkg::MODE_OAM:    phase_len = lmt_pkg::LEN_OAM;
         lmt_pkg::MODE_XFER:   phase_len = lmt_pkg::LEN_XFER;
         lmt_pkg::MODE_HBLANK: phase_len = lmt_pkg::LEN_HBLANK;
         lmt_pkg::MODE_VBLANK: phase_len = lmt_pkg::LEN_VLINE;
      endcase
      phase_end = acc_sum > phase_len;
   end

   // next state
   always_comb begin
      mode_in = mode_ff;
      line_in = line_ff;
      acc_in  = acc_sum;
      if (phase_end) begin
         acc_in = acc_sum - phase_len;
         unique case (mode_ff)
            lmt_pkg::MODE_OAM: begin
               mode_in = lmt_pkg::MODE_XFER;
            end
            lmt_pkg::MODE_XFER: begin
               mode_in = lmt_pkg::MODE_HBLANK;
            end
            lmt_pkg::MODE_HBLANK: begin
               line_in = line_inc[lmt_pkg::LINE_W-1:0];
               if (line_inc == lmt_pkg::VISIBLE_LINES) begin
                  mode_in = lmt_pkg::MODE_VBLANK;
               end else begin
                  mode_in = lmt_pkg::MODE_OAM;
               end
            end
            lmt_pkg::MODE_VBLANK: begin
               if (line_inc > lmt_pkg::LAST_LINE) begin
                  line_in = '0;
                  mode_in = lmt_pkg::MODE_OAM;
               end else begin
                  line_in = line_inc[lmt_pkg::LINE_W-1:0];
               end
            end
         endcase
      end
   end

   // result fields for this step
   always_comb begin
      result                = '0;
      result.mode           = mode_in;
      result.line           = line_in;
      if (phase_end) begin
         unique case (mode_ff)
            lmt_pkg::MODE_OAM: begin
            end
            lmt_pkg::MODE_XFER: begin
               result.render_request = 1'b1;
               result.stat_irq       = stat_en_ff[lmt_pkg::STAT_EN_HBLANK];
            end
            lmt_pkg::MODE_HBLANK: begin
               if (line_inc == lmt_pkg::VISIBLE_LINES) begin
                  result.vblank_irq = 1'b1;
                  result.frame_done = 1'b1;
                  result.stat_irq   = stat_en_ff[lmt_pkg::STAT_EN_VBLANK];
               end
            end
            lmt_pkg::MODE_VBLANK: begin
               if (line_inc > lmt_pkg::LAST_LINE) begin
                  result.stat_irq = stat_en_ff[lmt_pkg::STAT_EN_OAM];
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= lmt_pkg::MODE_OAM;
         line_ff    <= '0;
         acc_ff     <= '0;
         stat_en_ff <= '0;
      end else begin
         if (step_valid) begin
            mode_ff <= mode_in;
            line_ff <= line_in;
            acc_ff  <= acc_in;
         end
         if (csr_wr_en) begin
            stat_en_ff <= csr_wr_data;
         end
      end
   end

endmodule

### hdl/lmt_out_buf.sv
// ----------------------------------------------------------------------------
// lmt_out_buf
// Result register with a skid stage, so a new step can be taken while the
// previous result is still waiting on the receiver.
// ----------------------------------------------------------------------------
module lmt_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  lmt_pkg::result_type  push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output lmt_pkg::result_type  pop_data
);

   logic                 out_valid_ff;
   lmt_pkg::result_type  out_data_ff;
   logic                 skid_valid_ff;
   lmt_pkg::result_type  skid_data_ff;
   logic                 pop;

   assign push_ready = !skid_valid_ff;
   assign pop_valid  = out_valid_ff;
   assign pop_data   = out_data_ff;
   assign pop        = out_valid_ff && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         priority if (skid_valid_ff) begin
            if (pop) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (push_valid && out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else if (push_valid) begin
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= out_valid_ff;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (push_valid) begin
         if (out_valid_ff && !pop) begin
            skid_data_ff <= push_data;
         end else begin
            out_data_ff <= push_data;
         end
      end
   end

endmodule

### hdl/lcd_mode_timing_top.sv
// ----------------------------------------------------------------------------
// lcd_mode_timing_top
// Display mode and scanline timing: steps through oam scan, transfer,
// hblank and vblank from a stream of elapsed tick counts.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one transfer per step, req_tdata[5:0] = ticks elapsed.
//   rsp_ channel: one transfer per step with mode, line and event pulses.
//   csr_ port: csr_wr_en writes the three status interrupt enables.
// Each accepted step makes at most one mode change; leftover ticks carry
// into the next mode. The line counter runs 0..153, vblank starts at 144.
// Results are registered, in the skid entry while rsp_ is stalled. One step
// per cycle is sustained while the skid entry is free; the step logic is a
// single add, compare and subtract between the state and result registers.
// A result register plus one skid entry sit on the output: a stalled
// receiver holds rsp_ steady, one more step is still taken, and req_tready
// drops only once both entries are full.
// Reset puts the block in oam scan on line 0 with no ticks accumulated and
// all status enables cleared; no result is pending after reset.
// ----------------------------------------------------------------------------
module lcd_mode_timing_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lmt_pkg::REQ_DATA_W-1:0]      req_tdata,   // [5:0] tick_count
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [1:0] mode, [9:2] line, [10] vblank_irq, [11] stat_irq,
   // [12] render_request, [13] frame_done
   output logic [lmt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [lmt_pkg::STAT_EN_W-1:0]       csr_wr_data
);

   logic                 step_valid;
   lmt_pkg::result_type  step_result;
   lmt_pkg::result_type  rsp_result;

   assign step_valid = req_tvalid && req_tready;

   lmt_step u_step (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (step_valid),
      .tick_count  (req_tdata[lmt_pkg::TICK_W-1:0]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (step_result)
   );

   lmt_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (step_valid),
      .push_ready (req_tready),
      .push_data  (step_result),
      .pop_valid  (rsp_tvalid),
      .pop_ready  (rsp_tready),
      .pop_data   (rsp_result)
   );

   assign rsp_tdata = {{(lmt_pkg::RSP_DATA_W-lmt_pkg::RESULT_W){1'b0}}, rsp_result};

`ifndef ASSERT_OFF
   // vblank entry always marks the end of the visible frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_result.vblank_irq == rsp_result.frame_done))
      else $error("vblank_irq and frame_done disagree");

   // render request only on entry to hblank
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_result.render_request) |->
         (rsp_result.mode == lmt_pkg::MODE_HBLANK))
      else $error("render_request outside hblank");

   // frame done lands in vblank on the first invisible line
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_result.frame_done) |->
         (rsp_result.mode == lmt_pkg::MODE_VBLANK &&
          {1'b0, rsp_result.line} == lmt_pkg::VISIBLE_LINES))
      else $error("frame_done with wrong mode or line");

   // input is only held off while a result is waiting
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req_tready low with no pending result");
`endif

endmodule
